### rtl/tbrl_pkg.sv
// Shared constants, register codes and control types for the token bucket rate limiter.
package tbrl_pkg;

  localparam int TIME_WIDTH_DEF  = 48;
  localparam int TOKEN_WIDTH_DEF = 16;

  localparam int BURST_W    = 16;
  localparam int PERIOD_W   = 32;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_BURST_SIZE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REFILL_PERIOD = 1'b1;

  localparam logic [BURST_W-1:0]  BURST_RESET  = 16'd100;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 32'd1000;

  typedef struct packed {
    logic capture;
    logic div_start;
    logic div_step;
    logic refill_div;
    logic refill_full;
    logic decide;
  } ctrl_cmd_t;

  typedef struct packed {
    logic period_zero;
    logic too_soon;
  } dp_status_t;

endpackage

### rtl/tbrl_in_if.sv
// Request channel: timestamp and requested token count with valid/ready.
interface tbrl_in_if #(
  parameter int TIME_WIDTH  = tbrl_pkg::TIME_WIDTH_DEF,
  parameter int TOKEN_WIDTH = tbrl_pkg::TOKEN_WIDTH_DEF
);
  logic                   valid;
  logic                   ready;
  logic [TIME_WIDTH-1:0]  now_time;
  logic [TOKEN_WIDTH-1:0] requested_tokens;

  modport source (output valid, output now_time, output requested_tokens, input ready);
  modport sink   (input valid, input now_time, input requested_tokens, output ready);
endinterface

### rtl/tbrl_out_if.sv
// Result channel: grant flag and remaining tokens with valid/ready.
interface tbrl_out_if #(
  parameter int TOKEN_WIDTH = tbrl_pkg::TOKEN_WIDTH_DEF
);
  logic                   valid;
  logic                   ready;
  logic                   granted;
  logic [TOKEN_WIDTH-1:0] tokens_left;

  modport source (output valid, output granted, output tokens_left, input ready);
  modport sink   (input valid, input granted, input tokens_left, output ready);
endinterface

### rtl/tbrl_ctrl.sv
// Controller: sequences capture, refill check, serial divide, refill and decision.
module tbrl_ctrl #(
  parameter int TIME_WIDTH = tbrl_pkg::TIME_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  tbrl_pkg::dp_status_t   status,
  output tbrl_pkg::ctrl_cmd_t    cmd
);

  localparam int CNT_W = (TIME_WIDTH > 1) ? $clog2(TIME_WIDTH) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TIME_WIDTH - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_DIV    = 3'd2;
  localparam logic [2:0] S_REFILL = 3'd3;
  localparam logic [2:0] S_DECIDE = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             slot_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.period_zero) begin
          cmd.refill_full = 1'b1;
          state_nxt       = S_DECIDE;
        end else if (status.too_soon) begin
          state_nxt = S_DECIDE;
        end else begin
          cmd.div_start = 1'b1;
          cnt_nxt       = '0;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_LAST) begin
          state_nxt = S_REFILL;
        end
      end
      S_REFILL: begin
        cmd.refill_div = 1'b1;
        state_nxt      = S_DECIDE;
      end
      S_DECIDE: begin
        if (slot_free) begin
          cmd.decide = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = (out_valid_r && !out_ready) || cmd.decide;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_decide_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.decide |-> (!out_valid_r || out_ready))
    else $error("result written while output slot occupied");

  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && cnt_r == CNT_LAST) |=> state_r == S_REFILL)
    else $error("divide did not end after full step count");

  a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_CHECK && !in_ready))
    else $error("accepted item did not start processing");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("more than one datapath command at once");
`endif

endmodule

### rtl/tbrl_dp.sv
// Datapath: config registers, bucket state, serial divider and grant decision.
module tbrl_dp #(
  parameter int TIME_WIDTH  = tbrl_pkg::TIME_WIDTH_DEF,
  parameter int TOKEN_WIDTH = tbrl_pkg::TOKEN_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [tbrl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tbrl_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic [TIME_WIDTH-1:0]               now_time,
  input  logic [TOKEN_WIDTH-1:0]              requested_tokens,
  input  tbrl_pkg::ctrl_cmd_t                 cmd,
  output tbrl_pkg::dp_status_t                status,
  output logic                                granted,
  output logic [TOKEN_WIDTH-1:0]              tokens_left
);

  localparam int BW  = tbrl_pkg::BURST_W;
  localparam int PW  = tbrl_pkg::PERIOD_W;
  localparam int LW  = (BW > TOKEN_WIDTH) ? BW : TOKEN_WIDTH;
  localparam int EW  = (TIME_WIDTH > PW) ? TIME_WIDTH : PW;
  localparam int QW  = (TIME_WIDTH > TOKEN_WIDTH) ? TIME_WIDTH : TOKEN_WIDTH;

  localparam logic [LW-1:0] TOK_MAX = LW'({TOKEN_WIDTH{1'b1}});
  localparam logic [LW-1:0] RST_BURST_EXT = LW'(tbrl_pkg::BURST_RESET);
  localparam logic [LW-1:0] RST_LIMIT_EXT =
    (RST_BURST_EXT < TOK_MAX) ? RST_BURST_EXT : TOK_MAX;

  logic [BW-1:0]          burst_r;
  logic [PW-1:0]          period_r;
  logic [TOKEN_WIDTH-1:0] level_r, level_nxt;
  logic [TIME_WIDTH-1:0]  last_r;
  logic [TIME_WIDTH-1:0]  now_r;
  logic [TOKEN_WIDTH-1:0] want_r;
  logic [TIME_WIDTH-1:0]  elapsed_r;
  logic [PW-1:0]          rem_r;
  logic [TIME_WIDTH-1:0]  quo_r;
  logic                   granted_r;
  logic [TOKEN_WIDTH-1:0] tokens_left_r;

  logic [LW-1:0]          burst_ext;
  logic [LW-1:0]          limit_ext;
  logic [TOKEN_WIDTH-1:0] limit;
  logic [PW:0]            trial;
  logic                   trial_ge;
  logic [PW:0]            trial_diff;
  logic [QW-1:0]          quo_ext;
  logic [QW-1:0]          head_ext;
  logic                   fill_to_limit;

  assign burst_ext = LW'(burst_r);
  assign limit_ext = (burst_ext < TOK_MAX) ? burst_ext : TOK_MAX;
  assign limit     = limit_ext[TOKEN_WIDTH-1:0];

  assign status.period_zero = (period_r == '0);
  assign status.too_soon    = (EW'(elapsed_r) < EW'(period_r));

  assign trial      = {rem_r, quo_r[TIME_WIDTH-1]};
  assign trial_ge   = (trial >= {1'b0, period_r});
  assign trial_diff = trial - {1'b0, period_r};

  assign quo_ext       = QW'(quo_r);
  assign head_ext      = QW'(limit - level_r);
  assign fill_to_limit = (level_r >= limit) || (quo_ext >= head_ext);

  always_comb begin
    level_nxt = level_r;
    priority if (cmd.refill_full) begin
      level_nxt = limit;
    end else if (cmd.refill_div) begin
      level_nxt = fill_to_limit ? limit : (level_r + TOKEN_WIDTH'(quo_r));
    end else if (cmd.decide && (level_r >= want_r)) begin
      level_nxt = level_r - want_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      burst_r  <= tbrl_pkg::BURST_RESET;
      period_r <= tbrl_pkg::PERIOD_RESET;
      level_r  <= RST_LIMIT_EXT[TOKEN_WIDTH-1:0];
      last_r   <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          tbrl_pkg::CFG_BURST_SIZE:    burst_r  <= cfg_wdata[BW-1:0];
          tbrl_pkg::CFG_REFILL_PERIOD: period_r <= cfg_wdata[PW-1:0];
          default: ;
        endcase
      end
      level_r <= level_nxt;
      if (cmd.refill_full || cmd.refill_div) begin
        last_r <= now_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      now_r     <= now_time;
      want_r    <= requested_tokens;
      elapsed_r <= now_time - last_r;
    end
    if (cmd.div_start) begin
      rem_r <= '0;
      quo_r <= elapsed_r;
    end else if (cmd.div_step) begin
      rem_r <= trial_ge ? trial_diff[PW-1:0] : trial[PW-1:0];
      if (TIME_WIDTH > 1) begin
        quo_r <= {quo_r[TIME_WIDTH-2:0], trial_ge};
      end
    end
    if (cmd.decide) begin
      granted_r     <= (level_r >= want_r);
      tokens_left_r <= level_nxt;
    end
  end

  assign granted     = granted_r;
  assign tokens_left = tokens_left_r;

endmodule

### rtl/token_bucket_rate_limiter.sv
// Top level of the token bucket rate limiter: controller, datapath and channel wiring.
// Per item: capture, refill check, serial divide of the elapsed time by the period, refill,
// then decision; the divide and refill are skipped when the period has not yet elapsed, and a
// zero period fills the bucket instead. A new item is accepted only after the last is decided.
// Reset (synchronous, rst_n low): burst 100, period 1000, bucket full, last refill 0.
// A finished result waits in the output register while the next item is accepted.
module token_bucket_rate_limiter #(
  parameter int TIME_WIDTH  = tbrl_pkg::TIME_WIDTH_DEF,
  parameter int TOKEN_WIDTH = tbrl_pkg::TOKEN_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [tbrl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tbrl_pkg::CFG_DATA_W-1:0] cfg_wdata,
  tbrl_in_if.sink                         in_ch,
  tbrl_out_if.source                      out_ch
);

  tbrl_pkg::ctrl_cmd_t  cmd;
  tbrl_pkg::dp_status_t status;

  tbrl_ctrl #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  tbrl_dp #(
    .TIME_WIDTH  (TIME_WIDTH),
    .TOKEN_WIDTH (TOKEN_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .now_time         (in_ch.now_time),
    .requested_tokens (in_ch.requested_tokens),
    .cmd              (cmd),
    .status           (status),
    .granted          (out_ch.granted),
    .tokens_left      (out_ch.tokens_left)
  );

endmodule
